// ===== rtl/core/sosp_pkg.sv =====
// Shared sizes, codes and beat types for the set-of-stacks block.
// No dependencies; imported by sosp_dir and set_of_stacks_with_pop_at.
package sosp_pkg;

   localparam int MAX_STACKS = 16;
   localparam int CAP_MAX    = 64;
   localparam int DATA_WIDTH = 32;

   localparam int SLOT_W    = $clog2(MAX_STACKS);
   localparam int FILL_W    = $clog2(CAP_MAX + 1);
   localparam int OFS_W     = $clog2(CAP_MAX);
   localparam int ADDR_W    = SLOT_W + OFS_W;
   localparam int CNT_W     = $clog2(MAX_STACKS + 1);
   localparam int CAP_CFG_W = 7;
   localparam int IDX_W     = 5;
   localparam int STATUS_W  = 2;

   localparam logic [CAP_CFG_W-1:0] CAP_RESET = CAP_CFG_W'(64);

   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_INDEX = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

   typedef struct packed {
      logic                         operation;
      logic signed [DATA_WIDTH-1:0] push_value;
      logic [IDX_W-1:0]             stack_index;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] popped_value;
      logic [STATUS_W-1:0]          status;
      logic [CNT_W-1:0]             stacks_in_use;
   } rsp_type;

   // Directory decision for the beat on the input channel.
   typedef struct packed {
      logic                wr_en;
      logic                rd_en;
      logic [ADDR_W-1:0]   addr;
      logic [STATUS_W-1:0] status;
      logic [CNT_W-1:0]    count_after;
   } plan_type;

endpackage

// ===== rtl/core/set_of_stacks_with_pop_at.sv =====
// Top level of the set-of-stacks block with pop-at: config register,
// element memory and response register. Depends on sosp_pkg and sosp_dir.
//
//   channel | ports                          | direction | beat
//   --------+--------------------------------+-----------+------------------
//   req     | req_valid req_stall req_data   | in        | push or pop-at
//   rsp     | rsp_valid rsp_stall rsp_data   | out       | value/status/count
//   csr     | csr_wr_en csr_wr_data          | in        | stack capacity
//
// One beat per cycle sustained: a request is taken in the cycle that the
// previous response leaves (or whenever no response is waiting).
// The response is registered and shows in the cycle after its request is taken;
// on a pop, that register is the registered read of the single-port element memory.
// Synchronous active-high reset empties all stacks and sets the capacity to 64.
// req_stall is high only while a response waits under rsp_stall.
// The element memory needs no clearing pass: only entries below a fill are read.
module set_of_stacks_with_pop_at (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  sosp_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output sosp_pkg::rsp_type              rsp_data,
   input  logic                           csr_wr_en,
   input  logic [sosp_pkg::CAP_CFG_W-1:0] csr_wr_data
);
   import sosp_pkg::*;

   // capacity register and its clamped form (zero acts as one, cap at CAP_MAX)
   logic [CAP_CFG_W-1:0] cap_ff, cap_in, cap_eff;

   // handshake
   logic fire;

   // directory decision
   plan_type plan;

   // element memory, one stack slot per CAP_MAX-word region
   logic [DATA_WIDTH-1:0] elem_mem [MAX_STACKS * CAP_MAX];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] status_ff;
   logic [CNT_W-1:0]    count_ff;
   logic                pop_ok_ff;

   assign cap_in = csr_wr_en ? csr_wr_data : cap_ff;

   always_comb begin
      priority if (cap_ff == '0) begin
         cap_eff = CAP_CFG_W'(1);
      end else if (int'(cap_ff) > CAP_MAX) begin
         cap_eff = CAP_CFG_W'(CAP_MAX);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // a waiting response that is not being taken holds the request side
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign fire      = req_valid && !req_stall;

   sosp_dir u_dir (
      .clock (clock),
      .reset (reset),
      .fire  (fire),
      .req   (req_data),
      .cap   (cap_eff),
      .plan  (plan)
   );

   // push writes at the slot's fill; pop reads one below it. One access per beat.
   always_ff @(posedge clock) begin
      if (fire && plan.wr_en) begin
         elem_mem[plan.addr] <= req_data.push_value;
      end
      if (fire && plan.rd_en) begin
         rd_data_ff <= elem_mem[plan.addr];
      end
   end

   always_comb begin
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload; read data stays put until the next successful pop is taken
   always_ff @(posedge clock) begin
      if (fire) begin
         status_ff <= plan.status;
         count_ff  <= plan.count_after;
         pop_ok_ff <= plan.rd_en;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      rsp_data.popped_value  = pop_ok_ff ? rd_data_ff : '0;
      rsp_data.status        = status_ff;
      rsp_data.stacks_in_use = count_ff;
   end

   property p_beat_answers;
      @(posedge clock) disable iff (reset) fire |=> rsp_valid;
   endproperty
   a_beat_answers: assert property (p_beat_answers)
      else $error("accepted request produced no response");

   property p_status_code;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (rsp_data.status == ST_OK || rsp_data.status == ST_BAD_INDEX
                        || rsp_data.status == ST_FULL);
   endproperty
   a_status_code: assert property (p_status_code)
      else $error("undefined status code");

   property p_fail_zero;
      @(posedge clock) disable iff (reset)
         (rsp_valid && rsp_data.status != ST_OK) |-> (rsp_data.popped_value == '0);
   endproperty
   a_fail_zero: assert property (p_fail_zero)
      else $error("failed operation returned a value");

   property p_count_range;
      @(posedge clock) disable iff (reset)
         rsp_valid |-> (int'(rsp_data.stacks_in_use) <= MAX_STACKS);
   endproperty
   a_count_range: assert property (p_count_range)
      else $error("stack count out of range");

endmodule

// ===== rtl/core/sosp_dir.sv =====
// Stack directory: per-slot fill counts, newest-first order list, live count.
// Decides each beat's element memory access. Depends on sosp_pkg.
module sosp_dir (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         fire,
   input  sosp_pkg::req_type            req,
   input  logic [sosp_pkg::CAP_CFG_W-1:0] cap,
   output sosp_pkg::plan_type           plan
);
   import sosp_pkg::*;

   logic [FILL_W-1:0] fill_ff [MAX_STACKS];
   logic [FILL_W-1:0] fill_in [MAX_STACKS];
   logic [SLOT_W-1:0] order_ff [MAX_STACKS];
   logic [SLOT_W-1:0] order_in [MAX_STACKS];
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   logic [SLOT_W-1:0] top_slot, free_slot, push_slot, pop_slot;
   logic [FILL_W-1:0] top_fill, push_fill, pop_fill, pop_fill_dec;
   logic [IDX_W-1:0]  pos;
   logic              is_pop, open_new, push_ok, pop_ok, pop_empties;

   always_comb begin
      top_slot = order_ff[0];
      top_fill = fill_ff[top_slot];

      // lowest-numbered empty slot
      free_slot = '0;
      for (int i = MAX_STACKS - 1; i >= 0; i--) begin
         if (fill_ff[i] == '0) begin
            free_slot = SLOT_W'(i);
         end
      end

      open_new  = (count_ff == '0) || (int'(top_fill) >= int'(cap));
      push_slot = open_new ? free_slot : top_slot;
      push_fill = fill_ff[push_slot];
      push_ok   = !(open_new && (int'(count_ff) >= MAX_STACKS))
                  && (int'(push_fill) < CAP_MAX);

      pos          = (req.stack_index == '0) ? '0 : req.stack_index - IDX_W'(1);
      pop_slot     = order_ff[pos[SLOT_W-1:0]];
      pop_fill     = fill_ff[pop_slot];
      pop_fill_dec = pop_fill - FILL_W'(1);
      pop_ok       = (int'(req.stack_index) <= MAX_STACKS)
                     && (int'(pos) < int'(count_ff)) && (pop_fill != '0);
      pop_empties  = (pop_fill == FILL_W'(1));

      is_pop     = (req.operation == OP_POP);
      plan.wr_en = !is_pop && push_ok;
      plan.rd_en = is_pop && pop_ok;
      plan.addr  = is_pop ? {pop_slot, pop_fill_dec[OFS_W-1:0]}
                          : {push_slot, push_fill[OFS_W-1:0]};
      if (is_pop) begin
         plan.status = pop_ok ? ST_OK : ST_BAD_INDEX;
      end else begin
         plan.status = push_ok ? ST_OK : ST_FULL;
      end

      priority if (plan.wr_en && open_new) begin
         plan.count_after = count_ff + CNT_W'(1);
      end else if (plan.rd_en && pop_empties) begin
         plan.count_after = count_ff - CNT_W'(1);
      end else begin
         plan.count_after = count_ff;
      end
   end

   always_comb begin
      fill_in  = fill_ff;
      order_in = order_ff;
      count_in = count_ff;
      if (fire) begin
         count_in = plan.count_after;
         if (plan.wr_en) begin
            fill_in[push_slot] = push_fill + FILL_W'(1);
            if (open_new) begin
               order_in[0] = free_slot;
               for (int i = 1; i < MAX_STACKS; i++) begin
                  order_in[i] = order_ff[i-1];
               end
            end
         end
         if (plan.rd_en) begin
            fill_in[pop_slot] = pop_fill_dec;
            if (pop_empties) begin
               // close the gap left by the emptied stack
               for (int i = 0; i < MAX_STACKS - 1; i++) begin
                  if (i >= int'(pos)) begin
                     order_in[i] = order_ff[i+1];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MAX_STACKS; i++) begin
            fill_ff[i] <= '0;
         end
         count_ff <= '0;
      end else begin
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      order_ff <= order_in;
   end

   property p_one_access;
      @(posedge clock) disable iff (reset) !(plan.wr_en && plan.rd_en);
   endproperty
   a_one_access: assert property (p_one_access)
      else $error("element memory read and write in one beat");

   property p_count_bound;
      @(posedge clock) disable iff (reset) int'(count_ff) <= MAX_STACKS;
   endproperty
   a_count_bound: assert property (p_count_bound)
      else $error("live stack count above slot count");

   property p_count_step;
      @(posedge clock) disable iff (reset)
         !fire |=> (count_ff == $past(count_ff));
   endproperty
   a_count_step: assert property (p_count_step)
      else $error("live stack count moved without a beat");

endmodule
